[src/bbb_pkg.sv]
// Shared types and constants for the box boundary bisection block.
package bbb_pkg;

  // Iteration limit for one request; the search always settles well before it
  localparam int unsigned STEP_CAP = 64;
  localparam int unsigned STEP_W   = $clog2(STEP_CAP);

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_idx_t;

  localparam logic signed [15:0] BOX_LO_RST = -16'sd32768;
  localparam logic signed [15:0] BOX_HI_RST = 16'sd32767;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pt_t;

  typedef struct packed {
    pt_t lo;
    pt_t hi;
  } box_t;

  typedef struct packed {
    logic signed [15:0] near_x;
    logic signed [15:0] near_y;
    logic signed [15:0] near_z;
    logic signed [15:0] far_x;
    logic signed [15:0] far_y;
    logic signed [15:0] far_z;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] cross_x;
    logic signed [15:0] cross_y;
    logic signed [15:0] cross_z;
  } out_res_t;

  // Outcome of one bisection step
  typedef struct packed {
    pt_t  mid;
    logic done;
    logic outside;
  } step_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

[src/bbb_cfg.sv]
// Clip box register file written through the configuration channel.
module bbb_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [bbb_pkg::CFG_IDX_W-1:0]      wr_idx,
  input  logic [15:0]                        wr_data,
  output bbb_pkg::box_t                      box
);

  bbb_pkg::box_t box_r;
  bbb_pkg::box_t box_nxt;

  // Decode the register index; indexes past the map are dropped
  always_comb begin
    box_nxt = box_r;
    if (wr_en) begin
      unique case (wr_idx)
        bbb_pkg::CFG_BOX_MIN_X: box_nxt.lo.x = wr_data;
        bbb_pkg::CFG_BOX_MIN_Y: box_nxt.lo.y = wr_data;
        bbb_pkg::CFG_BOX_MIN_Z: box_nxt.lo.z = wr_data;
        bbb_pkg::CFG_BOX_MAX_X: box_nxt.hi.x = wr_data;
        bbb_pkg::CFG_BOX_MAX_Y: box_nxt.hi.y = wr_data;
        bbb_pkg::CFG_BOX_MAX_Z: box_nxt.hi.z = wr_data;
        default: box_nxt = box_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.lo.x <= bbb_pkg::BOX_LO_RST;
      box_r.lo.y <= bbb_pkg::BOX_LO_RST;
      box_r.lo.z <= bbb_pkg::BOX_LO_RST;
      box_r.hi.x <= bbb_pkg::BOX_HI_RST;
      box_r.hi.y <= bbb_pkg::BOX_HI_RST;
      box_r.hi.z <= bbb_pkg::BOX_HI_RST;
    end else begin
      box_r <= box_nxt;
    end
  end

  assign box = box_r;

endmodule

[src/bbb_step.sv]
// Shared bisection step unit: midpoint, convergence test and box outcode.
module bbb_step (
  input  bbb_pkg::pt_t      near_pt,
  input  bbb_pkg::pt_t      far_pt,
  input  bbb_pkg::box_t     box,
  output bbb_pkg::step_res_t res
);

  // Outcode bit positions
  localparam logic [5:0] OC_Z_HI = 6'h20;
  localparam logic [5:0] OC_Z_LO = 6'h10;
  localparam logic [5:0] OC_X_HI = 6'h08;
  localparam logic [5:0] OC_X_LO = 6'h04;
  localparam logic [5:0] OC_Y_HI = 6'h02;
  localparam logic [5:0] OC_Y_LO = 6'h01;

  // Floor of the mean: 17-bit sum, arithmetic shift right by one
  function automatic logic signed [15:0] floor_half(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    return s[16:1];
  endfunction

  bbb_pkg::pt_t mid;
  logic         same_near;
  logic         same_far;
  logic [5:0]   oc;

  // Form the midpoint on all three axes
  always_comb begin
    mid.x = floor_half(near_pt.x, far_pt.x);
    mid.y = floor_half(near_pt.y, far_pt.y);
    mid.z = floor_half(near_pt.z, far_pt.z);
  end

  // Stop once the midpoint no longer moves off an endpoint
  assign same_near = (mid == near_pt);
  assign same_far  = (mid == far_pt);

  // Strict signed compares against the box; the upper bound wins per axis
  always_comb begin
    oc = '0;
    if (box.hi.x < mid.x)      oc = oc | OC_X_HI;
    else if (mid.x < box.lo.x) oc = oc | OC_X_LO;
    if (box.hi.y < mid.y)      oc = oc | OC_Y_HI;
    else if (mid.y < box.lo.y) oc = oc | OC_Y_LO;
    if (box.hi.z < mid.z)      oc = oc | OC_Z_HI;
    else if (mid.z < box.lo.z) oc = oc | OC_Z_LO;
  end

  always_comb begin
    res.mid     = mid;
    res.done    = same_near | same_far;
    res.outside = (oc != 6'h00);
  end

endmodule

[src/box_boundary_bisect.sv]
// Top level: sequencer around the shared bisection step unit.
//
// Each request carries a near point and a far point; the block halves the segment
// once per clock through a single midpoint/outcode unit and returns the boundary
// point. The request is loaded at the accepting edge. Bisection then needs
// about 17 to 20 steps for full-range 16-bit coordinates and never
// more than 64 (step counter limit). busy stays high for exactly those step cycles
// and start is ignored. The result is presented in the cycle after the last step, for
// exactly one cycle with out_valid, and must be captured then; busy is already low in
// that cycle, so the next request may start at once. Configuration writes are taken
// every cycle (cfg_ready is tied high) and must only be issued while the block is idle.
module box_boundary_bisect (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bbb_pkg::in_req_t               in_req,
  output logic                           out_valid,
  output bbb_pkg::out_res_t              out_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  bbb_pkg::state_t    state_r;
  bbb_pkg::state_t    state_nxt;
  bbb_pkg::pt_t       near_r;
  bbb_pkg::pt_t       near_nxt;
  bbb_pkg::pt_t       far_r;
  bbb_pkg::pt_t       far_nxt;
  logic [bbb_pkg::STEP_W-1:0] step_cnt_r;
  logic [bbb_pkg::STEP_W-1:0] step_cnt_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  bbb_pkg::out_res_t  out_res_r;
  bbb_pkg::out_res_t  out_res_nxt;
  bbb_pkg::box_t      box;
  bbb_pkg::step_res_t step;
  logic               last_step;

  assign cfg_ready = 1'b1;

  bbb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .box     (box)
  );

  bbb_step u_step (
    .near_pt (near_r),
    .far_pt  (far_r),
    .box     (box),
    .res     (step)
  );

  assign last_step = (step_cnt_r == bbb_pkg::STEP_W'(bbb_pkg::STEP_CAP - 1));

  // Sequence the steps: load, iterate, emit
  always_comb begin
    state_nxt     = state_r;
    near_nxt      = near_r;
    far_nxt       = far_r;
    step_cnt_nxt  = step_cnt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    unique case (state_r)
      bbb_pkg::ST_IDLE: begin
        if (start) begin
          near_nxt.x   = in_req.near_x;
          near_nxt.y   = in_req.near_y;
          near_nxt.z   = in_req.near_z;
          far_nxt.x    = in_req.far_x;
          far_nxt.y    = in_req.far_y;
          far_nxt.z    = in_req.far_z;
          step_cnt_nxt = '0;
          state_nxt    = bbb_pkg::ST_RUN;
        end
      end
      bbb_pkg::ST_RUN: begin
        if (step.done || last_step) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.cross_x = step.mid.x;
          out_res_nxt.cross_y = step.mid.y;
          out_res_nxt.cross_z = step.mid.z;
          state_nxt           = bbb_pkg::ST_IDLE;
        end else begin
          // Outside midpoint replaces far, inside replaces near
          if (step.outside) begin
            far_nxt = step.mid;
          end else begin
            near_nxt = step.mid;
          end
          step_cnt_nxt = step_cnt_r + 1'b1;
        end
      end
      default: state_nxt = bbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbb_pkg::ST_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    near_r    <= near_nxt;
    far_r     <= far_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != bbb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Result strobe only appears once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  // Each result is a single-cycle pulse
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Step counter starts from zero on every request
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> (step_cnt_r == '0))
    else $error("step counter not cleared at request start");

endmodule

[test/box_boundary_bisect_checker.sv]
// Checker for the box boundary bisection block: predicts each crossing and compares results.
module box_boundary_bisect_checker
  import bbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_req_t               in_req,
  input  logic                  out_valid,
  input  out_res_t              out_res,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data,
  output int                    mismatch_count,
  output int                    crossings_due
);

  // Outcode bits, one pair per axis
  localparam logic [5:0] OC_X_ABOVE = 6'h08;
  localparam logic [5:0] OC_X_BELOW = 6'h04;
  localparam logic [5:0] OC_Y_ABOVE = 6'h02;
  localparam logic [5:0] OC_Y_BELOW = 6'h01;
  localparam logic [5:0] OC_Z_ABOVE = 6'h20;
  localparam logic [5:0] OC_Z_BELOW = 6'h10;

  box_t     clip_box;
  out_res_t expected_crossings[$];
  int       errors_seen = 0;
  int       due = 0;

  assign mismatch_count = errors_seen;
  assign crossings_due  = due;

  // Floor of the average of two signed coordinates
  function automatic logic signed [15:0] floor_half(logic signed [15:0] a,
                                                    logic signed [15:0] b);
    logic signed [16:0] sum;
    sum = $signed(a) + $signed(b);
    return sum[16:1];
  endfunction

  function automatic logic [5:0] box_outcode(pt_t p, box_t b);
    logic [5:0] code;
    code = '0;
    if ($signed(b.hi.x) < $signed(p.x)) code |= OC_X_ABOVE;
    else if ($signed(p.x) < $signed(b.lo.x)) code |= OC_X_BELOW;
    if ($signed(b.hi.y) < $signed(p.y)) code |= OC_Y_ABOVE;
    else if ($signed(p.y) < $signed(b.lo.y)) code |= OC_Y_BELOW;
    if ($signed(b.hi.z) < $signed(p.z)) code |= OC_Z_ABOVE;
    else if ($signed(p.z) < $signed(b.lo.z)) code |= OC_Z_BELOW;
    return code;
  endfunction

  // Bisect near/far until the midpoint stops moving or STEP_CAP steps are used; that midpoint is the crossing
  function automatic out_res_t bisect_crossing(in_req_t r, box_t b);
    pt_t      near_pt;
    pt_t      far_pt;
    pt_t      mid;
    logic     settled;
    int       step;
    out_res_t res;
    near_pt = '{x: r.near_x, y: r.near_y, z: r.near_z};
    far_pt  = '{x: r.far_x, y: r.far_y, z: r.far_z};
    mid     = '0;
    settled = 1'b0;
    for (step = 0; step < STEP_CAP && !settled; step++) begin
      mid.x = floor_half(near_pt.x, far_pt.x);
      mid.y = floor_half(near_pt.y, far_pt.y);
      mid.z = floor_half(near_pt.z, far_pt.z);
      if (mid == near_pt || mid == far_pt) begin
        settled = 1'b1;
      end else if (box_outcode(mid, b) != '0) begin
        far_pt = mid;
      end else begin
        near_pt = mid;
      end
    end
    res.cross_x = mid.x;
    res.cross_y = mid.y;
    res.cross_z = mid.z;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: crossing check: %s", $time, msg);
    errors_seen++;
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, want %0d", field, $signed(got), $signed(want)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clip_box.lo = '{x: BOX_LO_RST, y: BOX_LO_RST, z: BOX_LO_RST};
      clip_box.hi = '{x: BOX_HI_RST, y: BOX_HI_RST, z: BOX_HI_RST};
      expected_crossings.delete();
      due = 0;
    end else begin
      // Retire the oldest crossing first: a new request may start on the same edge
      if (out_valid) begin
        if (expected_crossings.size() == 0) begin
          report_mismatch($sformatf("unexpected result (%0d, %0d, %0d)",
                                    out_res.cross_x, out_res.cross_y, out_res.cross_z));
        end else begin
          out_res_t want;
          want = expected_crossings.pop_front();
          check_field("cross_x", out_res.cross_x, want.cross_x);
          check_field("cross_y", out_res.cross_y, want.cross_y);
          check_field("cross_z", out_res.cross_z, want.cross_z);
        end
      end
      if (start && !busy)
        expected_crossings.push_back(bisect_crossing(in_req, clip_box));
      // Track box registers; indexes past the map are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BOX_MIN_X: clip_box.lo.x = cfg_data;
          CFG_BOX_MIN_Y: clip_box.lo.y = cfg_data;
          CFG_BOX_MIN_Z: clip_box.lo.z = cfg_data;
          CFG_BOX_MAX_X: clip_box.hi.x = cfg_data;
          CFG_BOX_MAX_Y: clip_box.hi.y = cfg_data;
          CFG_BOX_MAX_Z: clip_box.hi.z = cfg_data;
          default: ;
        endcase
      end
      due = expected_crossings.size();
    end
  end

endmodule

[test/box_boundary_bisect_test.sv]
// Top of the box boundary bisection testbench: stimulus, configuration phases and verdict.
module box_boundary_bisect_test;
  import bbb_pkg::*;

  // Register indexes past the map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 78;

  // Box styles for the random phases
  localparam int BOX_FULL     = 0;
  localparam int BOX_RANDOM   = 1;
  localparam int BOX_TINY     = 2;
  localparam int BOX_INVERTED = 3;
  localparam int BOX_EDGE     = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_req_t               in_req;
  logic                  out_valid;
  out_res_t              out_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_data;
  int                    mismatch_count;
  int                    crossings_due;

  box_t box_now;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  box_boundary_bisect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  box_boundary_bisect_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .crossings_due  (crossings_due)
  );

  function automatic pt_t mk_pt(int x, int y, int z);
    pt_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.z = 16'(z);
    return p;
  endfunction

  function automatic in_req_t mk_req(pt_t n, pt_t f);
    return '{near_x: n.x, near_y: n.y, near_z: n.z, far_x: f.x, far_y: f.y, far_z: f.z};
  endfunction

  function automatic int rand16();
    logic signed [15:0] v;
    v = 16'($urandom);
    return int'(v);
  endfunction

  // Coordinate within [lo, hi], often on a bound; anything when the range is inverted
  function automatic int pick_in(int lo, int hi);
    int r;
    if (lo > hi) return rand16();
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Coordinate beyond one of the bounds where there is room
  function automatic int pick_out(int lo, int hi);
    if ($urandom_range(0, 1) && hi < 32767) return pick_in(hi + 1, 32767);
    if (lo > -32768) return pick_in(-32768, lo - 1);
    if (hi < 32767) return pick_in(hi + 1, 32767);
    return pick_in(lo, hi);
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 22);
    return $urandom_range(30, 90);
  endfunction

  // Mostly an inside near point and an outside far point; the rest swapped or raw noise
  function automatic in_req_t random_crossing_req(box_t b);
    int lo[3];
    int hi[3];
    int nc[3];
    int fc[3];
    int forced;
    int r;
    int a;
    lo = '{int'(b.lo.x), int'(b.lo.y), int'(b.lo.z)};
    hi = '{int'(b.hi.x), int'(b.hi.y), int'(b.hi.z)};
    forced = $urandom_range(0, 2);
    r = $urandom_range(0, 99);
    for (a = 0; a < 3; a++) begin
      if (r < 85) begin
        nc[a] = pick_in(lo[a], hi[a]);
        fc[a] = (a == forced || $urandom_range(0, 1)) ? pick_out(lo[a], hi[a])
                                                      : pick_in(lo[a], hi[a]);
      end else begin
        nc[a] = rand16();
        fc[a] = rand16();
      end
    end
    if (r >= 75 && r < 85)
      return mk_req(mk_pt(fc[0], fc[1], fc[2]), mk_pt(nc[0], nc[1], nc[2]));
    return mk_req(mk_pt(nc[0], nc[1], nc[2]), mk_pt(fc[0], fc[1], fc[2]));
  endfunction

  function automatic void axis_bounds(int style, output logic [15:0] lo,
                                      output logic [15:0] hi);
    int a;
    int c;
    int w;
    a = rand16();
    c = rand16();
    case (style)
      BOX_FULL: begin
        lo = BOX_LO_RST;
        hi = BOX_HI_RST;
      end
      BOX_RANDOM: begin
        lo = 16'((a < c) ? a : c);
        hi = 16'((a < c) ? c : a);
      end
      BOX_TINY: begin
        w  = $urandom_range(0, 20);
        a  = int'($urandom_range(0, 60000)) - 30000;
        lo = 16'(a - w);
        hi = 16'(a + w);
      end
      BOX_INVERTED: begin
        lo = 16'((a < c) ? c : a);
        hi = 16'((a < c) ? a : c);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          lo = BOX_HI_RST;
          hi = BOX_LO_RST;
        end else begin
          lo = 16'(a);
          hi = 16'(a);
        end
      end
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_box(box_t b, bit with_spare);
    write_reg(CFG_BOX_MIN_X, b.lo.x);
    write_reg(CFG_BOX_MIN_Y, b.lo.y);
    write_reg(CFG_BOX_MIN_Z, b.lo.z);
    write_reg(CFG_BOX_MAX_X, b.hi.x);
    write_reg(CFG_BOX_MAX_Y, b.hi.y);
    write_reg(CFG_BOX_MAX_Z, b.hi.z);
    if (with_spare) begin
      write_reg(CFG_IDX_SPARE_A, 16'($urandom));
      write_reg(CFG_IDX_SPARE_B, 16'($urandom));
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    box_now = b;
  endtask

  // Hold start until the block takes the request, then idle for the gap
  task automatic send_crossing_req(in_req_t req, int gap);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_pair(pt_t n, pt_t f);
    send_crossing_req(mk_req(n, f), idle_gap());
  endtask

  // Drop start and wait for every crossing in flight
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (crossings_due != 0) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("box_boundary_bisect_test: FAIL");
    $finish;
  end

  initial begin
    int   phase;
    int   n;
    int   style;
    bit   no_idle;
    box_t b;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    box_now.lo = '{x: BOX_LO_RST, y: BOX_LO_RST, z: BOX_LO_RST};
    box_now.hi = '{x: BOX_HI_RST, y: BOX_HI_RST, z: BOX_HI_RST};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset box spans everything: corners, coincident and adjacent endpoints
    send_pair(mk_pt(-32768, -32768, -32768), mk_pt(32767, 32767, 32767));
    send_pair(mk_pt(32767, 32767, 32767), mk_pt(-32768, -32768, -32768));
    send_pair(mk_pt(0, 0, 0), mk_pt(0, 0, 0));
    send_pair(mk_pt(32767, -32768, 32767), mk_pt(32767, -32768, 32767));
    send_pair(mk_pt(0, 0, 0), mk_pt(1, 1, 1));
    send_pair(mk_pt(-1, -1, -1), mk_pt(0, 0, 0));
    send_pair(mk_pt(-32768, 32767, 0), mk_pt(32767, -32768, -1));
    drain();

    // Ordinary box: exit through each face, both inside, both outside, a corner
    write_box('{lo: mk_pt(-1000, -200, -50), hi: mk_pt(1000, 300, 50)}, 1'b1);
    send_pair(mk_pt(0, 0, 0), mk_pt(20000, 0, 0));
    send_pair(mk_pt(0, 0, 0), mk_pt(-20000, 0, 0));
    send_pair(mk_pt(0, 0, 0), mk_pt(0, 9000, 0));
    send_pair(mk_pt(0, 0, 0), mk_pt(0, -9000, 0));
    send_pair(mk_pt(0, 0, 0), mk_pt(0, 0, 777));
    send_pair(mk_pt(0, 0, 0), mk_pt(0, 0, -777));
    send_pair(mk_pt(0, 0, 0), mk_pt(32767, 32767, 32767));
    send_pair(mk_pt(0, 0, 0), mk_pt(-32768, -32768, -32768));
    send_pair(mk_pt(10, 10, 10), mk_pt(-10, 20, -30));
    send_pair(mk_pt(5000, 5000, 5000), mk_pt(-5000, -5000, -5000));
    send_pair(mk_pt(-1000, -200, -50), mk_pt(-1001, -201, -51));
    drain();

    // Inverted box: every midpoint lands outside
    write_box('{lo: mk_pt(100, 100, 100), hi: mk_pt(-100, -100, -100)}, 1'b0);
    send_pair(mk_pt(0, 0, 0), mk_pt(500, -500, 0));
    send_pair(mk_pt(200, 200, 200), mk_pt(-200, -200, -200));
    drain();

    // Most extreme inverted bounds
    write_box('{lo: mk_pt(32767, 32767, 32767), hi: mk_pt(-32768, -32768, -32768)}, 1'b0);
    send_pair(mk_pt(0, 0, 0), mk_pt(32767, -32768, 1));
    drain();

    // Random phases, each with a fresh box
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      style = (phase <= BOX_EDGE) ? phase : $urandom_range(BOX_RANDOM, BOX_TINY);
      axis_bounds(style, b.lo.x, b.hi.x);
      axis_bounds(style, b.lo.y, b.hi.y);
      axis_bounds(style, b.lo.z, b.hi.z);
      write_box(b, 1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        send_crossing_req(random_crossing_req(box_now), no_idle ? 0 : idle_gap());
      drain();
    end

    repeat (STEP_CAP + 8) @(negedge clk);
    if (mismatch_count == 0)
      $display("box_boundary_bisect_test: PASS");
    else
      $display("box_boundary_bisect_test: FAIL");
    $finish;
  end

endmodule

[sim.f]
src/bbb_pkg.sv
src/bbb_cfg.sv
src/bbb_step.sv
src/box_boundary_bisect.sv
test/box_boundary_bisect_checker.sv
test/box_boundary_bisect_test.sv
